// File: sv/rpi_pkg.sv
// Shared types and constants for the ray/plane intersection unit.
package rpi_pkg;
    localparam int DataW     = 32;
    localparam int DistW     = 31;
    localparam int EpsW      = 16;
    localparam int DotW      = 66;
    localparam int FracBitsD = 16;
    localparam int NumRegs   = 7;
    localparam int IdxW      = 3;

    localparam logic [IdxW-1:0] RegNormalX = 3'd0;
    localparam logic [IdxW-1:0] RegNormalY = 3'd1;
    localparam logic [IdxW-1:0] RegNormalZ = 3'd2;
    localparam logic [IdxW-1:0] RegAnchorX = 3'd3;
    localparam logic [IdxW-1:0] RegAnchorY = 3'd4;
    localparam logic [IdxW-1:0] RegAnchorZ = 3'd5;
    localparam logic [IdxW-1:0] RegEps     = 3'd6;

    // Division state handed from cell to cell
    typedef struct packed {
        logic             valid;
        logic             live;
        logic [DistW-1:0] best;
        logic [64:0]      rem;
        logic [63:0]      den;
        logic [95:0]      num;
        logic [DistW-1:0] quo;
        logic             sat;
    } div_word_t;
endpackage

// File: sv/rpi_div_cell.sv
// One restoring-division cell: produces one quotient bit per cycle while adv is high.
module rpi_div_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  rpi_pkg::div_word_t in_word,
    output rpi_pkg::div_word_t out_word
);
    import rpi_pkg::*;

    div_word_t  word_reg;
    div_word_t  word_next;
    logic [64:0] shifted;
    logic        take;

    // Shift in next numerator bit, subtract when it fits
    always_comb begin
        word_next = in_word;
        shifted   = {in_word.rem[63:0], in_word.num[95]};
        take      = in_word.rem[64] || (shifted >= {1'b0, in_word.den});
        word_next.num = {in_word.num[94:0], 1'b0};
        word_next.rem = take ? (shifted - {1'b0, in_word.den}) : shifted;
        word_next.sat = in_word.sat | in_word.quo[DistW-1];
        word_next.quo = {in_word.quo[DistW-2:0], take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg.valid <= 1'b0;
        end else if (adv) begin
            word_reg.valid <= word_next.valid;
        end
        if (adv) begin
            word_reg.live <= word_next.live;
            word_reg.best <= word_next.best;
            word_reg.rem  <= word_next.rem;
            word_reg.den  <= word_next.den;
            word_reg.num  <= word_next.num;
            word_reg.quo  <= word_next.quo;
            word_reg.sat  <= word_next.sat;
        end
    end

    assign out_word = word_reg;
endmodule

// File: sv/rpi_front.sv
// Dot-product front end: products, sums, parallel test and divider load.
module rpi_front #(
    parameter int FRAC_BITS = rpi_pkg::FracBitsD
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        adv,
    input  logic                        in_valid,
    input  logic signed [rpi_pkg::DataW-1:0] nx, ny, nz, ax, ay, az,
    input  logic        [rpi_pkg::EpsW-1:0]  eps,
    input  logic signed [rpi_pkg::DataW-1:0] ox, oy, oz, vx, vy, vz,
    input  logic        [rpi_pkg::DistW-1:0] best,
    output rpi_pkg::div_word_t          out_word
);
    import rpi_pkg::*;

    // stage 1 registers: six products
    logic               v1_reg;
    logic [DistW-1:0]   b1_reg;
    logic signed [65:0] pd_reg [3];
    logic signed [65:0] pn_reg [3];
    // stage 2 registers: sums
    logic               v2_reg;
    logic [DistW-1:0]   b2_reg;
    logic signed [DotW-1:0] den_reg, num_reg;
    logic [EpsW-1:0]    eps_reg;
    logic signed [32:0] dx, dy, dz;
    logic signed [DotW-1:0] den_next, num_next;
    logic [DotW-1:0]    dmag, nmag;
    logic [DotW:0]      thresh;
    logic               live;
    logic [95:0]        num_sh;
    div_word_t          word_reg, word_next;

    assign dx = 33'(ax) - 33'(ox);
    assign dy = 33'(ay) - 33'(oy);
    assign dz = 33'(az) - 33'(oz);

    // Form the six products; register the sums, best distance and epsilon
    always_ff @(posedge aclk) begin
        if (adv) begin
            pd_reg[0] <= 66'(nx) * 66'(vx);
            pd_reg[1] <= 66'(ny) * 66'(vy);
            pd_reg[2] <= 66'(nz) * 66'(vz);
            pn_reg[0] <= 66'(dx) * 66'(nx);
            pn_reg[1] <= 66'(dy) * 66'(ny);
            pn_reg[2] <= 66'(dz) * 66'(nz);
            b1_reg    <= best;
            b2_reg    <= b1_reg;
            den_reg   <= den_next;
            num_reg   <= num_next;
            eps_reg   <= eps;
        end
    end

    assign den_next = pd_reg[0] + pd_reg[1] + pd_reg[2];
    assign num_next = pn_reg[0] + pn_reg[1] + pn_reg[2];

    // Magnitudes, parallel test and sign test; load the divider
    always_comb begin
        dmag   = den_reg[DotW-1] ? DotW'(-den_reg) : DotW'(den_reg);
        nmag   = num_reg[DotW-1] ? DotW'(-num_reg) : DotW'(num_reg);
        thresh = (DotW+1)'(eps_reg) << FRAC_BITS;
        live   = ({1'b0, dmag} > thresh) && (num_reg[DotW-1] == den_reg[DotW-1]);
        num_sh = 96'({nmag, FRAC_BITS'(0)});
        word_next.valid = v2_reg;
        word_next.live  = live;
        word_next.best  = b2_reg;
        word_next.den   = dmag[63:0];
        word_next.quo   = '0;
        // a quotient of 2^31 or more saturates at once
        word_next.sat   = live && (num_sh[95:31] >= {1'b0, dmag[63:0]});
        // start below quotient bit 31: the upper bits are zero unless saturated
        word_next.rem   = word_next.sat ? '0 : num_sh[95:31];
        word_next.num   = {num_sh[30:0], 65'd0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            word_reg.valid <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            word_reg.valid <= word_next.valid;
        end
        if (adv) begin
            word_reg.live <= word_next.live;
            word_reg.best <= word_next.best;
            word_reg.den  <= word_next.den;
            word_reg.quo  <= word_next.quo;
            word_reg.sat  <= word_next.sat;
            word_reg.rem  <= word_next.rem;
            word_reg.num  <= word_next.num;
        end
    end

    assign out_word = word_reg;
endmodule

// File: sv/ray_plane_intersect_unit.sv
// Top level: config registers, product front end, chain of divider cells.
// Pipeline: 3 + 31 = 34 register stages (front-end products, sums and divider load word, then the cells).
// Throughput: one ray per cycle; the pipeline stalls as a whole on m_tready.
// The chain of 31 divide cells (one quotient bit each) makes up most of the pipeline.
// Reset (aresetn low, synchronous) clears all valid bits and loads register
// defaults: normal (0,0,1.0), anchor 0, parallel epsilon 7.
module ray_plane_intersect_unit #(
    parameter int FRAC_BITS = rpi_pkg::FracBitsD
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, best_dist, pad
    input  logic [223:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // new_dist
    output logic [31:0]  m_tdata,
    // hit
    output logic         m_tuser,
    input  logic         cfg_we,
    input  logic [rpi_pkg::IdxW-1:0]  cfg_idx,
    input  logic [rpi_pkg::DataW-1:0] cfg_data
);
    import rpi_pkg::*;

    localparam int Cells = DistW;

    logic signed [DataW-1:0] nx_reg, ny_reg, nz_reg, ax_reg, ay_reg, az_reg;
    logic [EpsW-1:0] eps_reg;
    logic            adv;
    div_word_t       chain [Cells+1];
    logic            hit;

    // Hold the pipe only when the output word is stuck
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nx_reg <= '0; ny_reg <= '0; nz_reg <= DataW'(1) << FRAC_BITS;
            ax_reg <= '0; ay_reg <= '0; az_reg <= '0;
            eps_reg <= EpsW'(7);
        end else if (cfg_we) begin
            case (cfg_idx)
                RegNormalX: nx_reg  <= cfg_data;
                RegNormalY: ny_reg  <= cfg_data;
                RegNormalZ: nz_reg  <= cfg_data;
                RegAnchorX: ax_reg  <= cfg_data;
                RegAnchorY: ay_reg  <= cfg_data;
                RegAnchorZ: az_reg  <= cfg_data;
                RegEps:     eps_reg <= cfg_data[EpsW-1:0];
                default: ;
            endcase
        end
    end

    rpi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .aclk, .aresetn, .adv,
        .in_valid(s_tvalid),
        .nx(nx_reg), .ny(ny_reg), .nz(nz_reg),
        .ax(ax_reg), .ay(ay_reg), .az(az_reg), .eps(eps_reg),
        .ox(s_tdata[31:0]), .oy(s_tdata[63:32]), .oz(s_tdata[95:64]),
        .vx(s_tdata[127:96]), .vy(s_tdata[159:128]), .vz(s_tdata[191:160]),
        .best(s_tdata[222:192]),
        .out_word(chain[0])
    );

    for (genvar g = 0; g < Cells; g++) begin : g_cell
        rpi_div_cell u_cell (
            .aclk, .aresetn, .adv,
            .in_word(chain[g]),
            .out_word(chain[g+1])
        );
    end

    // Final compare: 0 < t < best
    assign hit = chain[Cells].live && !chain[Cells].sat &&
                 (chain[Cells].quo != '0) && (chain[Cells].quo < chain[Cells].best);
    assign m_tvalid = chain[Cells].valid;
    assign m_tuser  = hit;
    assign m_tdata  = {1'b0, hit ? chain[Cells].quo : chain[Cells].best};

    // A stalled result must not change
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    // A hit always shortens the distance
    a_short: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[30:0] < chain[Cells].best)
        else $error("hit not closer");
    // Saturated quotients never hit
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && chain[Cells].sat |-> !m_tuser)
        else $error("saturated hit");
endmodule

// File: bench/ray_plane_intersect_unit_test.sv
// Self-checking bench for the ray/plane intersection unit: directed and random rays.
module ray_plane_intersect_unit_test;
    import rpi_pkg::*;

    localparam int FracB    = 16;
    localparam int Latency  = 34;
    localparam int StallMax = 20000;

    typedef struct {
        logic [31:0] ox, oy, oz, dx, dy, dz;
        logic [30:0] best;
        logic        chk;
        logic        hit;
        logic [30:0] dist_val;
    } ray_row_t;

    typedef struct {
        logic        hit;
        logic [30:0] dist_val;
    } plane_hit_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [223:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;
    logic         m_tuser;
    logic         cfg_we;
    logic [IdxW-1:0]  cfg_idx;
    logic [DataW-1:0] cfg_data;

    // Plane registers as the bench believes them to be
    logic signed [31:0] plane_n [3];
    logic signed [31:0] plane_a [3];
    logic [15:0]        plane_eps;

    plane_hit_t pending_hits[$];
    ray_row_t   ray_table[$];
    int  failures;
    int  results_seen;
    int  hits_seen;
    int  idle_cycles;
    int  sink_hold;
    bit  sink_calm;

    ray_plane_intersect_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
    );

    always begin
        aclk = 1'b1; #5;
        aclk = 1'b0; #5;
    end

    // Compute the expected hit and distance for one ray
    function automatic plane_hit_t intersect_plane(ray_row_t r);
        logic signed [127:0] den, num, p;
        logic [127:0] dmag, nmag, q;
        logic [127:0] thresh;
        plane_hit_t res;
        den = $signed(plane_n[0]) * $signed(r.dx) + $signed(plane_n[1]) * $signed(r.dy)
            + $signed(plane_n[2]) * $signed(r.dz);
        num = 0;
        p = $signed(plane_a[0]) - $signed(r.ox); num = num + p * plane_n[0];
        p = $signed(plane_a[1]) - $signed(r.oy); num = num + p * plane_n[1];
        p = $signed(plane_a[2]) - $signed(r.oz); num = num + p * plane_n[2];
        res.hit = 1'b0;
        res.dist_val = r.best;
        dmag = den[127] ? -den : den;
        thresh = {96'd0, plane_eps, 16'd0};
        if (dmag > thresh && num[127] == den[127]) begin
            nmag = num[127] ? -num : num;
            q = (nmag << FracB) / dmag;
            if (q >= 128'h8000_0000) q = 128'h7FFF_FFFF;
            if (q != 0 && q < {97'd0, r.best}) begin
                res.hit = 1'b1;
                res.dist_val = q[30:0];
            end
        end
        return res;
    endfunction

    task automatic write_reg(input logic [IdxW-1:0] idx, input logic [31:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we   <= 1'b0;
        case (idx)
            RegNormalX: plane_n[0] = val;
            RegNormalY: plane_n[1] = val;
            RegNormalZ: plane_n[2] = val;
            RegAnchorX: plane_a[0] = val;
            RegAnchorY: plane_a[1] = val;
            RegAnchorZ: plane_a[2] = val;
            RegEps:     plane_eps = val[15:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Wait for the pipe to drain so registers can change safely
    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge aclk);
        repeat (Latency + 4) @(posedge aclk);
    endtask

    task automatic send_ray(input ray_row_t r, input bit may_idle);
        plane_hit_t e;
        if (may_idle && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, r.best, r.dz, r.dy, r.dx, r.oz, r.oy, r.ox};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        e = intersect_plane(r);
        if (r.chk && (e.hit !== r.hit || e.dist_val !== r.dist_val)) begin
            $display("%0t directed row disagrees with predictor: expected %0d/%h got %0d/%h",
                     $time, r.hit, r.dist_val, e.hit, e.dist_val);
            failures++;
        end
        pending_hits.push_back(e);
    endtask

    function automatic logic [31:0] rand_word(int mode);
        case (mode)
            0: return $urandom();
            1: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            2: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return $signed($urandom_range(0, 1 << 24)) - (1 << 23);
        endcase
    endfunction

    task automatic random_ray(input bit may_idle);
        ray_row_t r;
        int m;
        m = $urandom_range(0, 9) < 7 ? 3 : $urandom_range(0, 2);
        r.ox = rand_word(m); r.oy = rand_word(m); r.oz = rand_word(m);
        r.dx = rand_word(m); r.dy = rand_word(m); r.dz = rand_word(m);
        if ($urandom_range(0, 7) == 0) begin
            r.dx = 0; r.dy = 0; r.dz = $urandom_range(0, 15);
        end
        case ($urandom_range(0, 3))
            0: r.best = 31'($urandom());
            1: r.best = 31'h7FFF_FFFF;
            default: r.best = 31'($urandom_range(0, 1 << 26));
        endcase
        r.chk = 1'b0; r.hit = 1'b0; r.dist_val = '0;
        send_ray(r, may_idle);
    endtask

    // Result sink: random backpressure, compare against oldest expectation
    always @(posedge aclk) begin
        plane_hit_t e;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            sink_hold <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                idle_cycles <= 0;
                results_seen++;
                if (pending_hits.size() == 0) begin
                    $display("%0t unexpected result: expected none, got hit=%0d dist=%h",
                             $time, m_tuser, m_tdata[30:0]);
                    failures++;
                end else begin
                    e = pending_hits.pop_front();
                    if (e.hit) hits_seen++;
                    if (m_tuser !== e.hit) begin
                        $display("%0t hit mismatch: expected %0d, got %0d",
                                 $time, e.hit, m_tuser);
                        failures++;
                    end
                    if (m_tdata !== {1'b0, e.dist_val}) begin
                        $display("%0t dist mismatch: expected %h, got %h",
                                 $time, {1'b0, e.dist_val}, m_tdata);
                        failures++;
                    end
                end
            end else if (s_tvalid && s_tready) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            // Stall in random bursts, none once calm
            if (sink_calm) begin
                m_tready <= 1'b1;
            end else if (sink_hold > 0) begin
                sink_hold <= sink_hold - 1;
                m_tready  <= 1'b0;
            end else if ($urandom_range(0, 11) == 0) begin
                sink_hold <= $urandom_range(0, 13);
                m_tready  <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no accepted word
    always @(posedge aclk) begin
        if (idle_cycles > StallMax) begin
            $display("timeout with %0d results outstanding", pending_hits.size());
            $display("ray_plane_intersect_unit regression: fail");
            $finish;
        end
    end

    initial begin
        ray_row_t r;
        logic [31:0] extremes [4];
        extremes = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
        failures = 0; results_seen = 0; hits_seen = 0; idle_cycles = 0;
        sink_calm = 1'b0;
        aresetn = 1'b0; s_tvalid = 1'b0; s_tdata = '0;
        cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
        plane_n = '{32'd0, 32'd0, 32'd65536};
        plane_a = '{32'd0, 32'd0, 32'd0};
        plane_eps = 16'd7;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rays against the reset plane z = 0
        //            ox    oy  oz          dx  dy  dz           best        chk hit dist_val
        ray_table = '{
            '{32'd0, 32'd0, 32'h0002_0000, 32'd0, 32'd0, 32'hFFFF_0000, 31'h7FFF_FFFF,
              1'b1, 1'b1, 31'h0002_0000},
            '{32'd0, 32'd0, 32'h0002_0000, 32'd0, 32'd0, 32'h0001_0000, 31'h7FFF_FFFF,
              1'b1, 1'b0, 31'h7FFF_FFFF},
            '{32'd0, 32'd0, 32'h0002_0000, 32'd0, 32'd0, 32'hFFFF_0000, 31'h0001_0000,
              1'b1, 1'b0, 31'h0001_0000},
            '{32'd0, 32'd0, 32'h0002_0000, 32'd0, 32'd0, 32'hFFFF_0000, 31'h0002_0000,
              1'b1, 1'b0, 31'h0002_0000},
            '{32'd5, 32'd6, 32'h0001_0000, 32'd9, 32'd9, 32'hFFFF_FFF9, 31'h1234,
              1'b1, 1'b0, 31'h1234},
            '{32'd0, 32'd0, 32'h0001_0000, 32'd0, 32'd0, 32'hFFFF_FFF8, 31'h7FFF_FFFF,
              1'b1, 1'b1, 31'h2000_0000},
            '{32'd0, 32'd0, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFF8, 31'h7FFF_FFFF,
              1'b1, 1'b0, 31'h7FFF_FFFF},
            '{32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'h8000_0000, 31'h7FFF_FFFF,
              1'b1, 1'b0, 31'h7FFF_FFFF},
            '{32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 31'd0,
              1'b1, 1'b0, 31'd0},
            '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'd1, 32'h7FFF_FFFF,
              31'h5555_5555, 1'b0, 1'b0, 31'd0},
            '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 31'h2AAA_AAAA, 1'b0, 1'b0, 31'd0}
        };
        foreach (ray_table[i]) send_ray(ray_table[i], 1'b0);
        drain();

        // Extreme plane settings, including a wide epsilon
        for (int s = 0; s < 4; s++) begin
            write_reg(RegNormalX, extremes[s]);
            write_reg(RegNormalY, extremes[(s + 1) % 4]);
            write_reg(RegNormalZ, extremes[(s + 2) % 4]);
            write_reg(RegAnchorX, extremes[(s + 3) % 4]);
            write_reg(RegAnchorY, extremes[s]);
            write_reg(RegAnchorZ, extremes[(s + 1) % 4]);
            write_reg(RegEps, s[0] ? 32'h0000_FFFF : 32'd0);
            for (int k = 0; k < 30; k++) random_ray(1'b1);
            drain();
        end

        // Random planes, mostly with moderate values
        for (int ph = 0; ph < 10; ph++) begin
            for (int g = 0; g < 6; g++)
                write_reg(g[IdxW-1:0], $urandom_range(0, 4) == 0 ? $urandom()
                          : $signed($urandom_range(0, 1 << 20)) - (1 << 19));
            write_reg(RegEps, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 64));
            if (ph == 9) sink_calm = 1'b1;
            for (int k = 0; k < 132; k++) random_ray(ph != 9);
            drain();
        end

        $display("covered %0d rays over 15 plane settings, %0d hits, idle and stall bursts",
                 results_seen, hits_seen);
        if (failures == 0) begin
            $display("ray_plane_intersect_unit regression: pass");
        end else begin
            $display("ray_plane_intersect_unit regression: fail");
        end
        $finish;
    end
endmodule
